// ----- hdl/bdba_pkg.sv -----
// shared types and constants of the bitmap disk block allocator
// holds the sequencer state enum, result status codes and the
// command/status structs between controller and datapath
package bdba_pkg;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NOSPACE  = 2'd1;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd2;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // bitmap geometry: 8 bits per cylinder
  localparam int CYL_SHIFT = 3;

  // sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_FAIL,
    S_ALLOC_RD,
    S_ALLOC_EV,
    S_FIND_RD,
    S_FIND_EV,
    S_REL_RD,
    S_REL_EV
  } bdba_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic accept;       // latch request fields
    logic addr_clr;     // scan address back to block zero
    logic addr_inc;     // step scan address
    logic mem_clear;    // clear the used bit at scan address
    logic rd_en;        // read block entry at scan address
    logic find_reset;   // clear search and emit counters
    logic commit_alloc; // take serial, bump counter, charge free count
    logic alloc_mark;   // mark block used and emit its item
    logic find_eval;    // fold current block into newest-allocation search
    logic rel_clear;    // release block and emit its item
    logic emit_fail;    // emit a failure item
  } bdba_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic addr_last;   // scan address is the final block
    logic kind_free;   // latched request is a free
    logic alloc_fits;  // enough free blocks for the latched count
    logic blk_free;    // block just read is free
    logic blk_match;   // block just read belongs to the release target
    logic found;       // search has found an owned block, current one included
    logic out_ready;   // output register can take an item this cycle
    logic alloc_last;  // next allocated block completes the request
    logic rel_last;    // next released block completes the request
  } bdba_status_t;

endpackage

// ----- hdl/bdba_ctrl.sv -----
// sequencer of the bitmap disk block allocator
// depends on bdba_pkg; drives datapath commands from datapath status
module bdba_ctrl
  import bdba_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  bdba_status_t status_i,
  output bdba_cmd_t    cmd_o
);

  bdba_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (status_i.addr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (status_i.kind_free) begin
          state_d = S_FIND_RD;
        end else if (status_i.alloc_fits) begin
          state_d = S_ALLOC_RD;
        end else begin
          state_d = S_FAIL;
        end
      end
      S_FAIL: begin
        if (status_i.out_ready) state_d = S_IDLE;
      end
      S_ALLOC_RD: state_d = S_ALLOC_EV;
      S_ALLOC_EV: begin
        if (!status_i.blk_free) begin
          state_d = S_ALLOC_RD;
        end else if (status_i.out_ready) begin
          state_d = status_i.alloc_last ? S_IDLE : S_ALLOC_RD;
        end
      end
      S_FIND_RD: state_d = S_FIND_EV;
      S_FIND_EV: begin
        if (!status_i.addr_last) begin
          state_d = S_FIND_RD;
        end else begin
          state_d = status_i.found ? S_REL_RD : S_FAIL;
        end
      end
      S_REL_RD: state_d = S_REL_EV;
      S_REL_EV: begin
        if (!status_i.blk_match) begin
          state_d = S_REL_RD;
        end else if (status_i.out_ready) begin
          state_d = status_i.rel_last ? S_IDLE : S_REL_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_CLEAR: begin
        cmd_o.mem_clear = 1'b1;
        cmd_o.addr_inc  = !status_i.addr_last;
      end
      S_IDLE: begin
        cmd_o.accept = in_valid_i;
      end
      S_CHECK: begin
        cmd_o.addr_clr     = 1'b1;
        cmd_o.find_reset   = 1'b1;
        cmd_o.commit_alloc = !status_i.kind_free && status_i.alloc_fits;
      end
      S_FAIL: begin
        cmd_o.emit_fail = status_i.out_ready;
      end
      S_ALLOC_RD, S_FIND_RD, S_REL_RD: begin
        cmd_o.rd_en = 1'b1;
      end
      S_ALLOC_EV: begin
        if (!status_i.blk_free) begin
          cmd_o.addr_inc = 1'b1;
        end else if (status_i.out_ready) begin
          cmd_o.alloc_mark = 1'b1;
          cmd_o.addr_inc   = !status_i.alloc_last;
        end
      end
      S_FIND_EV: begin
        cmd_o.find_eval = 1'b1;
        cmd_o.addr_inc  = !status_i.addr_last;
        cmd_o.addr_clr  = status_i.addr_last;
      end
      S_REL_EV: begin
        if (!status_i.blk_match) begin
          cmd_o.addr_inc = 1'b1;
        end else if (status_i.out_ready) begin
          cmd_o.rel_clear = 1'b1;
          cmd_o.addr_inc  = !status_i.rel_last;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ----- hdl/bdba_dp.sv -----
// datapath of the bitmap disk block allocator: block table memory,
// request registers, counters, newest-allocation search and output register
// depends on bdba_pkg; commanded by bdba_ctrl
module bdba_dp
  import bdba_pkg::*;
#(
  parameter int BLOCK_COUNT       = 64,
  parameter int RECORDS_PER_TRACK = 4,
  parameter int NAME_BITS         = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  bdba_cmd_t    cmd_i,
  output bdba_status_t status_o,
  input  logic         kind_i,
  input  logic [15:0]  owner_name_i,
  input  logic [6:0]   block_count_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [1:0]   out_status_o,
  output logic [2:0]   cylinder_o,
  output logic         track_o,
  output logic [1:0]   record_o,
  output logic         last_o
);

  localparam int AW   = $clog2(BLOCK_COUNT);
  localparam int CW   = $clog2(BLOCK_COUNT + 1);
  localparam int CMPW = (CW > 7) ? CW : 7;
  localparam int MW   = 1 + NAME_BITS + 16;

  // block table: used bit, owner tag, serial tag
  logic [MW-1:0] blk_mem_q [BLOCK_COUNT];
  logic [MW-1:0] rd_data_q;
  logic [MW-1:0] wr_data;
  logic          wr_en;

  logic                 rd_used;
  logic [NAME_BITS-1:0] rd_owner;
  logic [15:0]          rd_serial;

  // request and control registers
  logic                 kind_q;
  logic [NAME_BITS-1:0] name_q;
  logic [6:0]           want_q;
  logic [AW-1:0]        addr_q;
  logic [15:0]          counter_q;
  logic [15:0]          serial_q;
  logic [CW-1:0]        free_cnt_q;
  logic [CW-1:0]        done_q;
  logic [CW-1:0]        total_q;
  logic                 found_q;
  logic [15:0]          best_age_q;
  logic [15:0]          target_q;

  logic [31:0]          name_ext;
  logic [CW-1:0]        done_inc;
  logic [CMPW-1:0]      want_ext;
  logic                 blk_owned;
  logic [15:0]          age;
  logic [2:0]           bit_idx;
  logic                 out_ready;

  // output register
  logic       out_valid_q;
  logic [1:0] out_status_q;
  logic [2:0] out_cyl_q;
  logic       out_track_q;
  logic [1:0] out_rec_q;
  logic       out_last_q;

  assign name_ext  = {16'b0, owner_name_i};
  assign rd_used   = rd_data_q[MW-1];
  assign rd_owner  = rd_data_q[MW-2 -: NAME_BITS];
  assign rd_serial = rd_data_q[15:0];
  assign done_inc  = CW'(done_q + 1'b1);
  assign want_ext  = CMPW'(want_q);
  assign blk_owned = rd_used && (rd_owner == name_q);
  assign age       = counter_q - rd_serial;
  assign bit_idx   = addr_q[2:0];
  assign out_ready = !out_valid_q || !out_stall_i;

  // status toward the controller
  always_comb begin
    status_o.addr_last  = (addr_q == AW'(BLOCK_COUNT - 1));
    status_o.kind_free  = (kind_q == KIND_FREE);
    status_o.alloc_fits = (want_q != 7'd0) && (want_ext <= CMPW'(free_cnt_q));
    status_o.blk_free   = !rd_used;
    status_o.blk_match  = blk_owned && (rd_serial == target_q);
    status_o.found      = found_q || blk_owned;
    status_o.out_ready  = out_ready;
    status_o.alloc_last = (CMPW'(done_inc) == want_ext);
    status_o.rel_last   = (done_inc == total_q);
  end

  // block table write data
  always_comb begin
    wr_en   = cmd_i.mem_clear || cmd_i.alloc_mark || cmd_i.rel_clear;
    wr_data = '0;
    if (cmd_i.alloc_mark) begin
      wr_data = {1'b1, name_q, serial_q};
    end else if (cmd_i.rel_clear) begin
      wr_data = {1'b0, rd_owner, rd_serial};
    end
  end

  // block table memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      blk_mem_q[addr_q] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= blk_mem_q[addr_q];
    end
  end

  // request fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= kind_i;
      name_q <= name_ext[NAME_BITS-1:0];
      want_q <= block_count_i;
    end
    if (cmd_i.commit_alloc) begin
      serial_q <= counter_q;
    end
  end

  // scan address, allocation counter, free count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q     <= '0;
      counter_q  <= '0;
      free_cnt_q <= CW'(BLOCK_COUNT);
    end else begin
      if (cmd_i.addr_clr) begin
        addr_q <= '0;
      end else if (cmd_i.addr_inc) begin
        addr_q <= AW'(addr_q + 1'b1);
      end
      if (cmd_i.commit_alloc) begin
        counter_q  <= counter_q + 16'd1;
        free_cnt_q <= free_cnt_q - CW'(want_q);
      end else if (cmd_i.rel_clear) begin
        free_cnt_q <= CW'(free_cnt_q + 1'b1);
      end
    end
  end

  // emit counter and newest-allocation search
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= '0;
      total_q <= '0;
      found_q <= 1'b0;
    end else begin
      if (cmd_i.find_reset) begin
        done_q  <= '0;
        total_q <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.alloc_mark || cmd_i.rel_clear) begin
          done_q <= done_inc;
        end
        if (cmd_i.find_eval && blk_owned) begin
          if (!found_q || (age < best_age_q)) begin
            found_q <= 1'b1;
            total_q <= CW'(1);
          end else if (age == best_age_q) begin
            total_q <= CW'(total_q + 1'b1);
          end
        end
      end
    end
  end

  // best candidate tags, payload only
  always_ff @(posedge clk_i) begin
    if (cmd_i.find_eval && blk_owned && (!found_q || (age < best_age_q))) begin
      best_age_q <= age;
      target_q   <= rd_serial;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.alloc_mark || cmd_i.rel_clear || cmd_i.emit_fail) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_fail) begin
      out_status_q <= (kind_q == KIND_FREE) ? STATUS_NOTFOUND : STATUS_NOSPACE;
      out_cyl_q    <= '0;
      out_track_q  <= 1'b0;
      out_rec_q    <= '0;
      out_last_q   <= 1'b1;
    end else if (cmd_i.alloc_mark || cmd_i.rel_clear) begin
      out_status_q <= STATUS_OK;
      out_cyl_q    <= 3'(addr_q >> CYL_SHIFT);
      out_track_q  <= 1'(32'(bit_idx) / RECORDS_PER_TRACK);
      out_rec_q    <= 2'(32'(bit_idx) % RECORDS_PER_TRACK);
      out_last_q   <= cmd_i.alloc_mark ? status_o.alloc_last : status_o.rel_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign cylinder_o   = out_cyl_q;
  assign track_o      = out_track_q;
  assign record_o     = out_rec_q;
  assign last_o       = out_last_q;

endmodule

// ----- hdl/bitmap_disk_block_allocator_unit.sv -----
// top level of the bitmap disk block allocator
// depends on bdba_pkg, bdba_ctrl and bdba_dp
//
// usage:
// - input channel (in_valid_i / in_stall_o) carries one request item:
//   kind_i 0 allocates block_count_i blocks for owner_name_i first-fit,
//   kind_i 1 frees the newest allocation held by owner_name_i
// - output channel (out_valid_o / out_stall_i) returns one item per block
//   touched, in block order, with last_o on the final one; a request that
//   cannot be served returns a single failure item with zero coordinates
// - one request is handled at a time; in_stall_o stays high until the
//   final item of the current request is in the output register
// - the block table is a single-port-read memory scanned one block at a
//   time in two steps (read, then evaluate); an allocate scans up to its
//   last block, a free scans every block to search and then scans again
//   up to its last released block for the release pass
// - after reset a clearing pass marks every block free; requests are
//   stalled until it ends
// - a stalled output holds its item and pauses the scan at that block
module bitmap_disk_block_allocator_unit
  import bdba_pkg::*;
#(
  parameter int BLOCK_COUNT       = 64,
  parameter int RECORDS_PER_TRACK = 4,
  parameter int NAME_BITS         = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [15:0] owner_name_i,
  input  logic [6:0]  block_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [2:0]  cylinder_o,
  output logic        track_o,
  output logic [1:0]  record_o,
  output logic        last_o
);

  bdba_cmd_t    cmd;
  bdba_status_t dp_status;

  // sequencer
  bdba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  // block table and result datapath
  bdba_dp #(
    .BLOCK_COUNT       (BLOCK_COUNT),
    .RECORDS_PER_TRACK (RECORDS_PER_TRACK),
    .NAME_BITS         (NAME_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (dp_status),
    .kind_i        (kind_i),
    .owner_name_i  (owner_name_i),
    .block_count_i (block_count_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_status_o  (status_o),
    .cylinder_o    (cylinder_o),
    .track_o       (track_o),
    .record_o      (record_o),
    .last_o        (last_o)
  );

endmodule

// ----- tb/sv/bitmap_disk_block_allocator_unit_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench of bitmap_disk_block_allocator_unit
// depends on bdba_pkg and the allocator rtl; predicts every result item
// from its own copy of the block bitmap, owner and serial tags
module bitmap_disk_block_allocator_unit_tb
  import bdba_pkg::*;
();

  localparam int DISK_BLOCKS  = 64;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 400;
  localparam int POOL_SIZE    = 6;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] cylinder;
    logic       track;
    logic [1:0] record;
    logic       last;
  } block_report_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic        kind_i        = KIND_ALLOC;
  logic [15:0] owner_name_i  = '0;
  logic [6:0]  block_count_i = '0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [1:0]  status_o;
  logic [2:0]  cylinder_o;
  logic        track_o;
  logic [1:0]  record_o;
  logic        last_o;

  // random idling on both sides while set
  bit jitter_on = 1'b1;
  int mismatches = 0;
  int quiet_cycles = 0;

  // predicted disk state
  logic        disk_used   [DISK_BLOCKS];
  logic [15:0] disk_owner  [DISK_BLOCKS];
  logic [15:0] disk_serial [DISK_BLOCKS];
  logic [15:0] alloc_serial_ctr = '0;

  logic [15:0] owner_pool [POOL_SIZE];
  block_report_t pending_reports [$];

  bitmap_disk_block_allocator_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .owner_name_i  (owner_name_i),
    .block_count_i (block_count_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .cylinder_o    (cylinder_o),
    .track_o       (track_o),
    .record_o      (record_o),
    .last_o        (last_o)
  );

  always #1 clk_i = ~clk_i;

  // block index to cylinder, track and record
  function automatic block_report_t block_report(logic [5:0] idx, logic is_last);
    block_report_t r;
    r.status   = STATUS_OK;
    r.cylinder = idx[5:3];
    r.track    = idx[2];
    r.record   = idx[1:0];
    r.last     = is_last;
    return r;
  endfunction

  // expected items of one request, updating the predicted disk state
  function automatic void predict_block_reports(logic k, logic [15:0] nm, logic [6:0] cnt);
    int b;
    int free_n;
    int done;
    int total;
    logic [16:0] best_age;
    logic [15:0] age;
    logic [15:0] target;
    block_report_t fail_r;
    free_n   = 0;
    done     = 0;
    total    = 0;
    best_age = 17'h10000;
    target   = '0;
    fail_r   = '0;
    fail_r.last = 1'b1;
    if (k == KIND_ALLOC) begin
      for (b = 0; b < DISK_BLOCKS; b++)
        if (!disk_used[b]) free_n++;
      if (cnt == 0 || cnt > free_n) begin
        fail_r.status = STATUS_NOSPACE;
        pending_reports.push_back(fail_r);
      end else begin
        // first fit in scan order, all blocks share one serial
        for (b = 0; b < DISK_BLOCKS && done < cnt; b++) begin
          if (!disk_used[b]) begin
            disk_used[b]   = 1'b1;
            disk_owner[b]  = nm;
            disk_serial[b] = alloc_serial_ctr;
            done++;
            pending_reports.push_back(block_report(b[5:0], done == cnt));
          end
        end
        alloc_serial_ctr = alloc_serial_ctr + 16'd1;
      end
    end else begin
      // newest allocation of this owner has the smallest age
      for (b = 0; b < DISK_BLOCKS; b++) begin
        if (disk_used[b] && disk_owner[b] == nm) begin
          age = alloc_serial_ctr - disk_serial[b];
          if ({1'b0, age} < best_age) begin
            best_age = {1'b0, age};
            target   = disk_serial[b];
          end
        end
      end
      if (best_age[16]) begin
        fail_r.status = STATUS_NOTFOUND;
        pending_reports.push_back(fail_r);
      end else begin
        for (b = 0; b < DISK_BLOCKS; b++)
          if (disk_used[b] && disk_owner[b] == nm && disk_serial[b] == target) total++;
        for (b = 0; b < DISK_BLOCKS; b++) begin
          if (disk_used[b] && disk_owner[b] == nm && disk_serial[b] == target) begin
            disk_used[b] = 1'b0;
            done++;
            pending_reports.push_back(block_report(b[5:0], done == total));
          end
        end
      end
    end
  endfunction

  function automatic void compare_field(string field, int want, int got);
    if (want != got) begin
      $display("%0t mismatch on %s: expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // output stall and result check
  always @(posedge clk_i) begin : result_check
    block_report_t want;
    block_report_t got;
    out_stall_i <= jitter_on && ($urandom_range(0, 99) < 38);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {status_o, cylinder_o, track_o, record_o, last_o};
      if (pending_reports.size() == 0) begin
        $display("%0t unexpected item: expected none, actual %p", $time, got);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        compare_field("status", want.status, got.status);
        compare_field("cylinder", want.cylinder, got.cylinder);
        compare_field("track", want.track, got.track);
        compare_field("record", want.record, got.record);
        compare_field("last", want.last, got.last);
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // offer one request item and record its expected results on acceptance
  task automatic send_request(input logic k, input logic [15:0] nm, input logic [6:0] cnt);
    while (jitter_on && $urandom_range(0, 99) < 38) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= k;
    owner_name_i  <= nm;
    block_count_i <= cnt;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    predict_block_reports(k, nm, cnt);
  endtask

  // hold the sender until every expected item has come
  task automatic wait_for_reports();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_reports.size() != 0);
  endtask

  // zero count, oversize counts and an unknown owner
  task automatic test_failures();
    send_request(KIND_ALLOC, 16'h0001, 7'd0);
    send_request(KIND_ALLOC, 16'h0002, 7'd65);
    send_request(KIND_ALLOC, 16'h0003, 7'd127);
    send_request(KIND_FREE, 16'h4242, 7'd127);
  endtask

  // fill the disk exactly, then overflow and release
  task automatic test_exact_fit();
    send_request(KIND_ALLOC, 16'h0000, 7'd1);
    send_request(KIND_ALLOC, 16'hFFFF, 7'd5);
    send_request(KIND_ALLOC, 16'hA5A5, 7'd64);
    send_request(KIND_ALLOC, 16'h1234, 7'd58);
    send_request(KIND_ALLOC, 16'h0001, 7'd1);
    send_request(KIND_FREE, 16'h0000, 7'd0);
    send_request(KIND_FREE, 16'hFFFF, 7'd64);
    send_request(KIND_FREE, 16'h1234, 7'd1);
    send_request(KIND_FREE, 16'hFFFF, 7'd0);
  endtask

  // an owner with two allocations gives back the newest first
  task automatic test_newest_allocation();
    send_request(KIND_ALLOC, 16'h5A5A, 7'd3);
    send_request(KIND_ALLOC, 16'h0F0F, 7'd2);
    send_request(KIND_ALLOC, 16'h5A5A, 7'd4);
    send_request(KIND_FREE, 16'h5A5A, 7'd0);
    send_request(KIND_FREE, 16'h5A5A, 7'd0);
    send_request(KIND_FREE, 16'h0F0F, 7'd0);
  endtask

  // whole disk in one request
  task automatic test_full_disk();
    send_request(KIND_ALLOC, 16'h7777, 7'd64);
    send_request(KIND_ALLOC, 16'h7777, 7'd1);
    send_request(KIND_FREE, 16'h7777, 7'd0);
  endtask

  // mixed allocate and free traffic over a small pool of owners
  task automatic test_random_traffic(input int n);
    logic [15:0] nm;
    logic [6:0]  cnt;
    int pick;
    for (int i = 0; i < POOL_SIZE; i++) owner_pool[i] = 16'($urandom_range(0, 65535));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 10) nm = 16'($urandom_range(0, 65535));
      else nm = owner_pool[$urandom_range(0, POOL_SIZE - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 4) cnt = 7'd0;
      else if (pick < 10) cnt = 7'($urandom_range(64, 127));
      else if (pick < 20) cnt = 7'($urandom_range(9, 40));
      else cnt = 7'($urandom_range(1, 8));
      if ($urandom_range(0, 99) < 55) begin
        send_request(KIND_ALLOC, nm, cnt);
      end else begin
        send_request(KIND_FREE, nm, 7'($urandom_range(0, 127)));
      end
    end
  endtask

  initial begin
    for (int b = 0; b < DISK_BLOCKS; b++) begin
      disk_used[b]   = 1'b0;
      disk_owner[b]  = '0;
      disk_serial[b] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_failures();
    test_exact_fit();
    test_newest_allocation();
    test_full_disk();
    // long stretch without idling on either side
    wait_for_reports();
    jitter_on <= 1'b0;
    test_random_traffic(70);
    wait_for_reports();
    jitter_on <= 1'b1;
    test_random_traffic(180);
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/bdba_pkg.sv
hdl/bdba_ctrl.sv
hdl/bdba_dp.sv
hdl/bitmap_disk_block_allocator_unit.sv
tb/sv/bitmap_disk_block_allocator_unit_tb.sv
